// File: rtl/tdp_pkg.sv
`default_nettype none

package tdp_pkg;

  localparam int NUMBER_WIDTH_DEF = 32;

  // status of the remainder unit back to the sequencer
  typedef struct packed {
    logic done;
    logic zero;
  } tdp_rem_stat_t;

endpackage

`default_nettype wire

// File: rtl/trial_division_primality_test.sv
// trial division primality test
// input: drive in_number and raise start; the transaction is taken at the edge
// where start is high and busy is low. busy stays high until the answer is out.
// output: out_valid pulses for exactly one cycle with out_prime; the receiver
// cannot stall, so the result must be taken in that cycle.
// divisors run upward from 2 while d*d <= number; d*d is kept as a running
// square (d+1)^2 = d^2 + 2d + 1, so no multiplier is needed.
// each divisor takes one bound check, a pass of NUMBER_WIDTH dividend bits
// through the bit-serial remainder unit and a read of its status.
// numbers below 4 are answered from the bound check without any division.
// one number is in flight at a time; the next can be started in the cycle
// that out_valid is high.
// reset (synchronous, active low) returns the sequencer to idle and drops any
// number in progress without a result.
`default_nettype none

module trial_division_primality_test import tdp_pkg::*; #(
  parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [NUMBER_WIDTH-1:0] in_number,
  output logic                         out_valid,
  output logic                         out_prime
);

  localparam int DW = (NUMBER_WIDTH + 1) / 2 + 1;
  localparam int SW = NUMBER_WIDTH + 1;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_CHECK = 3'b010,
    ST_DIV   = 3'b100
  } state_t;

  state_t                  state_r, state_nxt;
  logic [NUMBER_WIDTH-1:0] n_r, n_nxt;
  logic [DW-1:0]           d_r, d_nxt;
  logic [SW-1:0]           sq_r, sq_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_prime_r, out_prime_nxt;
  logic                    rem_start;
  tdp_rem_stat_t           rem_stat;

  tdp_rem #(
    .NUMBER_WIDTH (NUMBER_WIDTH),
    .DIV_WIDTH    (DW)
  ) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (n_r),
    .divisor  (d_r),
    .stat     (rem_stat)
  );

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    d_nxt         = d_r;
    sq_nxt        = sq_r;
    out_valid_nxt = 1'b0;
    out_prime_nxt = out_prime_r;
    rem_start     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          n_nxt     = in_number;
          d_nxt     = DW'(2);
          sq_nxt    = SW'(4);
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        priority if (n_r < NUMBER_WIDTH'(2)) begin
          out_valid_nxt = 1'b1;
          out_prime_nxt = 1'b0;
          state_nxt     = ST_IDLE;
        end else if (sq_r > {1'b0, n_r}) begin
          // no divisor left below the square root
          out_valid_nxt = 1'b1;
          out_prime_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          rem_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (rem_stat.done) begin
          if (rem_stat.zero) begin
            out_valid_nxt = 1'b1;
            out_prime_nxt = 1'b0;
            state_nxt     = ST_IDLE;
          end else begin
            d_nxt     = d_r + DW'(1);
            sq_nxt    = sq_r + (SW'(d_r) << 1) + SW'(1);
            state_nxt = ST_CHECK;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    d_r         <= d_nxt;
    sq_r        <= sq_nxt;
    out_prime_r <= out_prime_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_prime = out_prime_r;

  // busy only drops together with a result
  a_busy_fall_result: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $fell(busy) |-> out_valid)
    else $error("busy fell without a result");

  // a result strobe is a single-cycle pulse
  a_valid_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("out_valid held longer than one cycle");

  // an accepted transaction makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  // the remainder unit only reports while a division is pending
  a_rem_done_div: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && rem_stat.done |-> state_r == ST_DIV)
    else $error("remainder done outside divide state");

endmodule

`default_nettype wire

// File: rtl/tdp_rem.sv
`default_nettype none

module tdp_rem import tdp_pkg::*; #(
  parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF,
  parameter int DIV_WIDTH    = (NUMBER_WIDTH + 1) / 2 + 1
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic [NUMBER_WIDTH-1:0] dividend,
  input  wire logic [DIV_WIDTH-1:0]    divisor,
  output tdp_rem_stat_t                stat
);

  localparam int CW = $clog2(NUMBER_WIDTH + 1);

  logic [NUMBER_WIDTH-1:0] sh_r, sh_nxt;
  logic [DIV_WIDTH-1:0]    rem_r, rem_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic                    done_r, done_nxt;
  logic [DIV_WIDTH:0]      trial;

  // restoring division, one dividend bit per cycle, msb first
  assign trial = {rem_r, sh_r[NUMBER_WIDTH-1]};

  always_comb begin
    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      sh_nxt  = dividend;
      rem_nxt = '0;
      cnt_nxt = CW'(NUMBER_WIDTH);
    end else if (cnt_r != '0) begin
      sh_nxt = {sh_r[NUMBER_WIDTH-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = DIV_WIDTH'(trial - {1'b0, divisor});
      end else begin
        rem_nxt = trial[DIV_WIDTH-1:0];
      end
      cnt_nxt  = cnt_r - CW'(1);
      done_nxt = (cnt_r == CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r  <= sh_nxt;
    rem_r <= rem_nxt;
  end

  assign stat.done = done_r;
  assign stat.zero = (rem_r == '0);

endmodule

`default_nettype wire

// File: tb/prime_flag_checker.sv
`timescale 1ns / 1ps

module prime_flag_checker import tdp_pkg::*; #(
  parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic                    busy,
  input  logic [NUMBER_WIDTH-1:0] in_number,
  input  logic                    out_valid,
  input  logic                    out_prime,
  output int                      mismatch_count,
  output int                      flags_outstanding
);

  typedef struct {
    longint unsigned number;
    bit              prime;
  } prime_query_t;

  prime_query_t pending_queries[$];

  initial begin
    mismatch_count = 0;
    flags_outstanding = 0;
  end

  // trial division, bound written as d <= n / d so it cannot overflow
  function automatic bit prime_flag(longint unsigned n);
    longint unsigned d;
    if (n < 2) return 1'b0;
    for (d = 2; d <= n / d; d++) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic report(string what);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  always @(posedge clk) begin : watch
    prime_query_t oldest;
    prime_query_t fresh;
    if (rst_n) begin
      // retire the result first: a new transaction may be taken in the same cycle
      if (out_valid) begin
        if (pending_queries.size() == 0) begin
          report($sformatf("result prime=%0b with no transaction waiting", out_prime));
        end else begin
          oldest = pending_queries.pop_front();
          if (out_prime !== oldest.prime)
            report($sformatf("number %0d: prime=%0b, expected %0b",
                             oldest.number, out_prime, oldest.prime));
        end
      end
      if (start && !busy) begin
        fresh.number = 64'(in_number);
        fresh.prime = prime_flag(fresh.number);
        pending_queries = {pending_queries, fresh};
      end
    end
    flags_outstanding = pending_queries.size();
  end

endmodule

// File: tb/trial_division_primality_test_tb.sv
`timescale 1ns / 1ps

module trial_division_primality_test_tb import tdp_pkg::*;;

  localparam int NW = NUMBER_WIDTH_DEF;
  localparam int RANDOM_ITEMS = 100;
  // the slowest stimulus runs divisors up to 1024
  localparam int unsigned CYCLE_LIMIT = 4_000_000;

  logic          clk = 1'b0;
  logic          rst_n;
  logic          start;
  logic          busy;
  logic [NW-1:0] in_number;
  logic          out_valid;
  logic          out_prime;
  int            mismatch_count;
  int            flags_outstanding;
  int unsigned   cycle_count = 0;

  always #4 clk = ~clk;

  trial_division_primality_test #(.NUMBER_WIDTH(NW)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_number (in_number),
    .out_valid (out_valid),
    .out_prime (out_prime)
  );

  prime_flag_checker #(.NUMBER_WIDTH(NW)) u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_number         (in_number),
    .out_valid         (out_valid),
    .out_prime         (out_prime),
    .mismatch_count    (mismatch_count),
    .flags_outstanding (flags_outstanding)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Regression FAIL");
      $finish;
    end
  end

  // hold start high with the number until the block takes the transaction
  task automatic send_number(input logic [NW-1:0] n);
    @(negedge clk);
    start <= 1'b1;
    in_number <= n;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic hold_off(input int cycles);
    @(negedge clk);
    start <= 1'b0;
    in_number <= $urandom;
    repeat (cycles - 1) @(negedge clk) in_number <= $urandom;
  endtask

  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (flags_outstanding != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    logic [NW-1:0] corners [22];
    int            small_primes [5];
    logic [NW-1:0] n;
    int            sent;
    int            burst;
    int            pick;

    corners = '{
      0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 11, 25, 49, 121,
      32'hFFFF_FFFF,   // all ones, factor 3
      32'hFFFF_FFFE,
      32'h8000_0000,
      32'h5555_5555,
      32'hAAAA_AAAA,
      65537,           // prime, runs divisors up to 256
      1022117,         // 1009 * 1013, first factor found late
      1048573          // largest prime below 2^20
    };
    small_primes = '{3, 5, 7, 11, 13};

    rst_n = 1'b0;
    start = 1'b0;
    in_number = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    foreach (corners[i]) begin
      send_number(corners[i]);
      if (i % 5 == 4) hold_off($urandom_range(1, 4));
    end
    drain_results();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
        pick = $urandom_range(0, 9);
        case (pick)
          0, 1, 2, 3: n = $urandom_range(0, 1023);
          4, 5:       n = $urandom_range(1024, 65535);
          6:          n = $urandom & 32'hFFFF_FFFE;
          7: begin
            // wide value with a small factor so the search ends early
            n = $urandom;
            n = n - n % small_primes[$urandom_range(0, 4)];
          end
          8: begin
            // squares land exactly on the divisor bound
            n = $urandom_range(2, 255);
            n = n * n;
          end
          default: begin
            if (sent % 20 == 0) n = $urandom_range(65536, 1048575);
            else n = $urandom_range(2, 300);
          end
        endcase
        send_number(n);
        sent++;
        if (sent == RANDOM_ITEMS / 2) drain_results();
      end
      if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 9));
    end

    drain_results();
    repeat (20) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/tdp_pkg.sv
rtl/tdp_rem.sv
rtl/trial_division_primality_test.sv
tb/prime_flag_checker.sv
tb/trial_division_primality_test_tb.sv
